// ===== rtl/hsl_to_rgb_with_wrap_darkening_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef HSL_TO_RGB_WITH_WRAP_DARKENING_TOP_DEFINES_SVH
`define HSL_TO_RGB_WITH_WRAP_DARKENING_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define HSLTR_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSLTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hsltr_pkg.sv =====
package hsltr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int HUE_W     = 24;
    localparam int SAT_W     = 17;
    localparam int LEVEL_W   = 8;

    localparam int TURN_W = HUE_W - FRAC_BITS;  // whole turns in the hue
    localparam int HW     = FRAC_BITS + 1;      // wrapped hue, 0..ONE
    localparam int LW     = HUE_W;              // darkened lightness, signed
    localparam int VW     = HUE_W + 2;          // v1 / v2, signed
    localparam int PW     = LW + SAT_W + 2;     // lightness product, signed
    localparam int DW     = VW + 1;             // v2 - v1, signed
    localparam int FW     = FRAC_BITS + 1;      // hue ramp factor, unsigned
    localparam int MW     = DW + FW + 1;        // ramp product, signed
    localparam int XW     = DW + 1;             // channel value, signed

    localparam int NUM_STAGES = 7;

    localparam longint ONE        = 64'sd1 <<< FRAC_BITS;
    localparam longint FIFTH      = (ONE + 2) / 5;
    localparam longint THIRD      = ONE / 3;
    localparam longint TWO_THIRDS = (2 * ONE + 1) / 3;
    localparam longint HALF       = ONE / 2;
    localparam longint SIXTH_CEIL = (ONE + 5) / 6;      // 6*h < ONE  <=> h < this
    localparam longint TT_CEIL    = (2 * ONE + 2) / 3;  // 3*h < 2*ONE <=> h < this

    // hue offset applied by a channel lane
    localparam logic [1:0] SHIFT_UP   = 2'd0;
    localparam logic [1:0] SHIFT_NONE = 2'd1;
    localparam logic [1:0] SHIFT_DOWN = 2'd2;

    typedef struct packed {
        logic [HUE_W-1:0] hue_turns;
        logic [SAT_W-1:0] saturation;
        logic [SAT_W-1:0] lightness;
    } in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } out_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

    // shared intermediates handed from the front end to the lanes
    typedef struct packed {
        logic [VW-1:0] v2;
        logic [LW-1:0] light;
        logic [HW-1:0] hue;
    } front_t;

endpackage

// ===== rtl/hsltr_ctrl.sv =====
module hsltr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hsltr_pkg::pipe_ctl_t  ctl
);

    localparam int N = hsltr_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] upstream;
    logic [N:0]   rdy;

    // a stage takes new data when it is empty or its successor moves on
    always_comb begin
        rdy[N] = m_ready;
        for (int i = N - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign upstream = {valid_reg[N-2:0], s_valid};

    always_comb begin
        for (int i = 0; i < N; i++) begin
            valid_next[i] = rdy[i] ? upstream[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load = rdy[N-1:0];
    assign s_ready  = rdy[0];
    assign m_valid  = valid_reg[N-1];

endmodule

// ===== rtl/hsltr_front.sv =====
module hsltr_front (
    input  logic                  aclk,
    input  hsltr_pkg::in_t        in_data,
    input  hsltr_pkg::pipe_ctl_t  ctl,
    output hsltr_pkg::front_t     front
);

    localparam int HUE_W     = hsltr_pkg::HUE_W;
    localparam int SAT_W     = hsltr_pkg::SAT_W;
    localparam int FRAC_BITS = hsltr_pkg::FRAC_BITS;
    localparam int TURN_W    = hsltr_pkg::TURN_W;
    localparam int HW        = hsltr_pkg::HW;
    localparam int LW        = hsltr_pkg::LW;
    localparam int VW        = hsltr_pkg::VW;
    localparam int PW        = hsltr_pkg::PW;

    // stage 1: hue wrap and darkening
    logic [HUE_W-1:0]     hue_m1;
    logic                 wrap;
    logic [TURN_W-1:0]    turns;
    logic [LW-1:0]        dark;
    logic [HW-1:0]        h1_next, h1_reg;
    logic signed [LW-1:0] l1_next, l1_reg;
    logic [SAT_W-1:0]     s1_next, s1_reg;

    always_comb begin
        hue_m1  = in_data.hue_turns - HUE_W'(1);
        wrap    = in_data.hue_turns > HUE_W'(hsltr_pkg::ONE);
        turns   = wrap ? hue_m1[HUE_W-1:FRAC_BITS] : '0;
        h1_next = wrap ? HW'(hue_m1[FRAC_BITS-1:0]) + HW'(1)
                       : in_data.hue_turns[HW-1:0];
        dark    = LW'(turns) * LW'(hsltr_pkg::FIFTH);
        l1_next = $signed(LW'(in_data.lightness)) - $signed(dark);
        s1_next = in_data.saturation;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            h1_reg <= h1_next;
            l1_reg <= l1_next;
            s1_reg <= s1_next;
        end
    end

    // stage 2: one product serves both lightness branches
    logic                 lo2_next, lo2_reg;
    logic [SAT_W:0]       mul_op;
    logic signed [PW-1:0] p2_next, p2_reg;
    logic signed [LW-1:0] ls2_next, ls2_reg;
    logic [HW-1:0]        h2_reg;
    logic signed [LW-1:0] l2_reg;

    always_comb begin
        lo2_next = l1_reg < LW'(hsltr_pkg::HALF);
        mul_op   = lo2_next ? (SAT_W+1)'(hsltr_pkg::ONE) + (SAT_W+1)'(s1_reg)
                            : (SAT_W+1)'(s1_reg);
        p2_next  = $signed(PW'(l1_reg)) * $signed(PW'({1'b0, mul_op}));
        ls2_next = l1_reg + $signed(LW'(s1_reg));
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            lo2_reg <= lo2_next;
            p2_reg  <= p2_next;
            ls2_reg <= ls2_next;
            h2_reg  <= h1_reg;
            l2_reg  <= l1_reg;
        end
    end

    // stage 3: v2, product divided by ONE toward zero
    logic signed [PW-1:0] p_adj;
    logic signed [PW-1:0] p_shr;
    logic signed [VW-1:0] q;
    logic signed [VW-1:0] v2_next, v2_reg;
    logic [HW-1:0]        h3_reg;
    logic signed [LW-1:0] l3_reg;

    always_comb begin
        p_adj   = p2_reg + (p2_reg[PW-1] ? PW'(hsltr_pkg::ONE - 1) : PW'(0));
        p_shr   = p_adj >>> FRAC_BITS;
        q       = VW'(p_shr);
        v2_next = lo2_reg ? q : VW'(ls2_reg) - q;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            v2_reg <= v2_next;
            h3_reg <= h2_reg;
            l3_reg <= l2_reg;
        end
    end

    assign front.v2    = v2_reg;
    assign front.light = l3_reg;
    assign front.hue   = h3_reg;

endmodule

// ===== rtl/hsltr_lane.sv =====
module hsltr_lane (
    input  logic                          aclk,
    input  hsltr_pkg::pipe_ctl_t          ctl,
    input  hsltr_pkg::front_t             front,
    input  logic [1:0]                    shift_sel,
    output logic [hsltr_pkg::LEVEL_W-1:0] level
);

    localparam int FRAC_BITS = hsltr_pkg::FRAC_BITS;
    localparam int LEVEL_W   = hsltr_pkg::LEVEL_W;
    localparam int HW        = hsltr_pkg::HW;
    localparam int VW        = hsltr_pkg::VW;
    localparam int DW        = hsltr_pkg::DW;
    localparam int FW        = hsltr_pkg::FW;
    localparam int MW        = hsltr_pkg::MW;
    localparam int XW        = hsltr_pkg::XW;
    localparam int SW        = HW + 2;  // offset hue before wrap, signed

    localparam logic [1:0] RG_RISE = 2'd0;
    localparam logic [1:0] RG_HIGH = 2'd1;
    localparam logic [1:0] RG_FALL = 2'd2;
    localparam logic [1:0] RG_LOW  = 2'd3;

    // stage 4: hue offset, region, ramp factor, v1 and v2 - v1
    logic signed [SW-1:0] hue_off;
    logic signed [SW-1:0] hue_raw;
    logic [HW-1:0]        hue_w;
    logic [FW-1:0]        fall_base;
    logic signed [VW-1:0] l_ext;
    logic signed [VW-1:0] v2_in;
    logic [1:0]           rg4_next, rg4_reg;
    logic [FW-1:0]        fac4_next, fac4_reg;
    logic signed [VW-1:0] v1_4_next, v1_4_reg;
    logic signed [VW-1:0] v2_4_reg;
    logic signed [DW-1:0] diff4_next, diff4_reg;

    always_comb begin
        unique case (shift_sel)
            hsltr_pkg::SHIFT_UP:   hue_off = SW'(hsltr_pkg::THIRD);
            hsltr_pkg::SHIFT_DOWN: hue_off = -SW'(hsltr_pkg::THIRD);
            default:               hue_off = '0;
        endcase
        hue_raw = $signed(SW'(front.hue)) + hue_off;
        if (hue_raw < 0) begin
            hue_w = HW'(hue_raw + SW'(hsltr_pkg::ONE));
        end else if (hue_raw > SW'(hsltr_pkg::ONE)) begin
            hue_w = HW'(hue_raw - SW'(hsltr_pkg::ONE));
        end else begin
            hue_w = HW'(hue_raw);
        end

        fall_base = FW'(hsltr_pkg::TWO_THIRDS) - FW'(hue_w);
        if (hue_w < HW'(hsltr_pkg::SIXTH_CEIL)) begin
            rg4_next  = RG_RISE;
            fac4_next = FW'(hue_w) * FW'(6);
        end else if (hue_w < HW'(hsltr_pkg::HALF)) begin
            rg4_next  = RG_HIGH;
            fac4_next = '0;
        end else if (hue_w < HW'(hsltr_pkg::TT_CEIL)) begin
            rg4_next  = RG_FALL;
            fac4_next = fall_base * FW'(6);
        end else begin
            rg4_next  = RG_LOW;
            fac4_next = '0;
        end

        l_ext      = VW'($signed(front.light));
        v2_in      = $signed(front.v2);
        v1_4_next  = (l_ext <<< 1) - v2_in;
        diff4_next = (DW'(v2_in) - DW'(l_ext)) <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            rg4_reg   <= rg4_next;
            fac4_reg  <= fac4_next;
            v1_4_reg  <= v1_4_next;
            v2_4_reg  <= v2_in;
            diff4_reg <= diff4_next;
        end
    end

    // stage 5: ramp product
    logic signed [MW-1:0] prod5_next, prod5_reg;
    logic signed [VW-1:0] v1_5_reg, v2_5_reg;
    logic [1:0]           rg5_reg;

    assign prod5_next = $signed(MW'(diff4_reg)) * $signed(MW'({1'b0, fac4_reg}));

    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            prod5_reg <= prod5_next;
            v1_5_reg  <= v1_4_reg;
            v2_5_reg  <= v2_4_reg;
            rg5_reg   <= rg4_reg;
        end
    end

    // stage 6: channel value
    logic signed [MW-1:0] prod_adj;
    logic signed [MW-1:0] prod_shr;
    logic signed [XW-1:0] x6_next, x6_reg;

    always_comb begin
        prod_adj = prod5_reg + (prod5_reg[MW-1] ? MW'(hsltr_pkg::ONE - 1) : MW'(0));
        prod_shr = prod_adj >>> FRAC_BITS;
        case (rg5_reg)
            RG_RISE, RG_FALL: x6_next = XW'(v1_5_reg) + XW'(prod_shr);
            RG_HIGH:          x6_next = XW'(v2_5_reg);
            default:          x6_next = XW'(v1_5_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[5]) begin
            x6_reg <= x6_next;
        end
    end

    // stage 7: scale by 255, truncate, clamp
    logic [XW+LEVEL_W-1:0] scaled;
    logic [XW+LEVEL_W-1:0] scaled_q;
    logic [LEVEL_W-1:0]    level7_next, level7_reg;

    always_comb begin
        scaled   = {x6_reg, LEVEL_W'(0)} - (XW+LEVEL_W)'(unsigned'(x6_reg));
        scaled_q = scaled >> FRAC_BITS;
        if (x6_reg[XW-1]) begin
            level7_next = '0;
        end else if (|scaled_q[XW+LEVEL_W-1:LEVEL_W]) begin
            level7_next = '1;
        end else begin
            level7_next = scaled_q[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[6]) begin
            level7_reg <= level7_next;
        end
    end

    assign level = level7_reg;

endmodule

// ===== rtl/hsl_to_rgb_with_wrap_darkening_top.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    hsltr_pkg::in_t  (hue_turns, saturation, lightness)
// m_        out  m_valid/m_ready    hsltr_pkg::out_t (red_level, green_level, blue_level)
//
// Seven register stages, one transfer per cycle in and out while m_ready stays high.
// Each of the three channel lanes has its own ramp multiplier.
// aresetn (synchronous) clears only the stage valid bits; data registers are not reset.
// Each stage holds while its successor is full and stalled, so empty stages
// keep filling and s_ready stays high until all seven stages hold a result.
module hsl_to_rgb_with_wrap_darkening_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  hsltr_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output hsltr_pkg::out_t  m_data
);

    hsltr_pkg::pipe_ctl_t ctl;
    hsltr_pkg::front_t    front;

    logic [hsltr_pkg::LEVEL_W-1:0] red_lvl;
    logic [hsltr_pkg::LEVEL_W-1:0] green_lvl;
    logic [hsltr_pkg::LEVEL_W-1:0] blue_lvl;

    hsltr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    hsltr_front u_front (
        .aclk    (aclk),
        .in_data (s_data),
        .ctl     (ctl),
        .front   (front)
    );

    hsltr_lane u_lane_red (
        .aclk      (aclk),
        .ctl       (ctl),
        .front     (front),
        .shift_sel (hsltr_pkg::SHIFT_UP),
        .level     (red_lvl)
    );

    hsltr_lane u_lane_green (
        .aclk      (aclk),
        .ctl       (ctl),
        .front     (front),
        .shift_sel (hsltr_pkg::SHIFT_NONE),
        .level     (green_lvl)
    );

    hsltr_lane u_lane_blue (
        .aclk      (aclk),
        .ctl       (ctl),
        .front     (front),
        .shift_sel (hsltr_pkg::SHIFT_DOWN),
        .level     (blue_lvl)
    );

    assign m_data.red_level   = red_lvl;
    assign m_data.green_level = green_lvl;
    assign m_data.blue_level  = blue_lvl;

endmodule

// ===== rtl/hsltr_checker.sv =====
`include "hsl_to_rgb_with_wrap_darkening_top_defines.svh"

module hsltr_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input hsltr_pkg::out_t m_data
);

    localparam int CW = $clog2(hsltr_pkg::NUM_STAGES + 2);

    // items accepted but not yet delivered
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    assign cnt_next = cnt_reg + CW'(s_valid && s_ready) - CW'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `HSLTR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result lost or changed")
    `HSLTR_ASSERT_NOW(a_out_has_item, m_valid |-> (cnt_reg != '0), "result without an accepted item")
    `HSLTR_ASSERT_NOW(a_occupancy, cnt_reg <= CW'(hsltr_pkg::NUM_STAGES), "more items in flight than stages")
    `HSLTR_ASSERT_NOW(a_ready_when_drained, !m_valid |-> s_ready, "input blocked with output stage empty")

endmodule

bind hsl_to_rgb_with_wrap_darkening_top hsltr_checker u_checker (.*);
